### rtl/tpds_pkg.sv
// ============================================================================
// Deadline timer pool package
// Field widths, operation and status codes, register indexes and defaults.
// ============================================================================
package tpds_pkg;

    // Field widths
    localparam int OP_W      = 2;
    localparam int NOW_W     = 64;
    localparam int DELAY_W   = 32;
    localparam int SLOT_W    = 6;
    localparam int STATUS_W  = 2;
    localparam int TPU_W     = 10;
    localparam int SLICE_W   = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;
    localparam int PROD_W    = DELAY_W + TPU_W;

    // Packed stream widths (whole bytes)
    localparam int S_DATA_W = 104;
    localparam int M_DATA_W = 72;

    // Defaults
    localparam int                 TIMER_SLOTS_DEF = 16;
    localparam logic [TPU_W-1:0]   TPU_RST         = 10'd10;
    localparam logic [SLICE_W-1:0] SLICE_RST       = 32'd100000;
    localparam logic [NOW_W-1:0]   NO_DEADLINE     = '1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEL  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;
    localparam logic [OP_W-1:0] OP_NEXT = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTVALID = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE     = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TPU   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE = 1'b1;

endpackage

### rtl/timer_pool_deadline_scheduler.sv
// ============================================================================
// Deadline timer pool scheduler
// A pool of one-shot timers with add, delete, expiry scan and next-deadline
// query operations. Deadlines live in a single-port synchronous memory.
// ============================================================================
//
// Channel     | Direction | Handshake                     | Contents
// ------------+-----------+-------------------------------+--------------------------------
// s_axis      | in        | tvalid / tready               | tuser op, tdata now/delay/slot
// m_axis      | out       | tvalid / tready, tlast        | tuser status, tdata slot/value
// cfg         | in        | write enable, no wait         | ticks_per_us, slice_ticks
//
// Timing: a delete checks its slot's valid bit, with no scan. An add scans the
// valid bits one slot per cycle until the first free slot. Tick and next stream
// the deadline memory one slot per cycle through its single read port, but for
// a stall of the tick scan. One transaction is in work at a time; a finished
// result waits in the output register while the next input transaction is
// taken. Reset clears the valid bits at once, so there is no clearing pass. A
// stalled output holds the tick scan in place when a second expired slot is
// found; the other operations wait with their result until the output is free.
// ============================================================================
module timer_pool_deadline_scheduler
    import tpds_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [S_DATA_W-1:0]   i_s_axis_tdata,   // now[63:0], delay_us[95:64], slot[101:96]
    input  logic [OP_W-1:0]       i_s_axis_tuser,   // op[1:0]
    // Result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [M_DATA_W-1:0]   o_m_axis_tdata,   // result_slot[5:0], tick_value[69:6]
    output logic [STATUS_W-1:0]   o_m_axis_tuser,   // status[1:0]
    output logic                  o_m_axis_tlast,
    // Configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DAT_W-1:0]  i_cfg_wdata
);

    // Slot index width and a scan counter one bit wider so it can hold the end.
    localparam int SLOT_IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int IW      = SLOT_IW + 1;
    localparam logic [IW-1:0]     IDX_END  = IW'(TIMER_SLOTS);
    localparam logic [SLOT_W:0]   SLOT_LIM = (SLOT_W + 1)'(TIMER_SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_DEL,
        S_TICK,
        S_NEXT
    } t_state;

    // Input fields
    logic [NOW_W-1:0]   in_now;
    logic [DELAY_W-1:0] in_delay;
    logic [SLOT_W-1:0]  in_slot;

    assign in_now   = i_s_axis_tdata[NOW_W-1:0];
    assign in_delay = i_s_axis_tdata[NOW_W+DELAY_W-1:NOW_W];
    assign in_slot  = i_s_axis_tdata[NOW_W+DELAY_W+SLOT_W-1:NOW_W+DELAY_W];

    // Control state
    t_state                 r_state;
    logic [TIMER_SLOTS-1:0] r_valid;
    logic [IW-1:0]          r_idx;
    logic                   r_chk_vld;
    logic [SLOT_IW-1:0]     r_chk_idx;
    logic                   r_pend_vld;
    logic                   r_out_vld;

    // Configuration registers
    logic [TPU_W-1:0]       r_tpu;
    logic [SLICE_W-1:0]     r_slice;

    // Payload registers
    logic [NOW_W-1:0]       r_now;
    logic [PROD_W-1:0]      r_prod;
    logic [SLOT_W-1:0]      r_slot;
    logic [NOW_W-1:0]       r_best;
    logic [SLOT_IW-1:0]     r_pend_slot;
    logic [NOW_W-1:0]       r_pend_dl;
    logic [STATUS_W-1:0]    r_out_status;
    logic [SLOT_W-1:0]      r_out_slot;
    logic [NOW_W-1:0]       r_out_value;
    logic                   r_out_last;

    // Deadline memory, one read or write per cycle, registered read data.
    logic [NOW_W-1:0]       mem_dl [TIMER_SLOTS];
    logic [NOW_W-1:0]       r_rd_data;

    // Datapath and control decisions
    logic                   s_acc;
    logic                   out_free;
    logic [SLOT_IW-1:0]     idx_lo;
    logic                   scan_issue;
    logic                   scan_done;
    logic                   hit;
    logic                   tick_stall;
    logic                   scan_adv;
    logic                   mem_re;
    logic                   add_take;
    logic [NOW_W-1:0]       add_dl;
    logic                   del_ok;
    logic                   emit;
    logic [STATUS_W-1:0]    e_status;
    logic [SLOT_W-1:0]      e_slot;
    logic [NOW_W-1:0]       e_value;
    logic                   e_last;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_vld || i_m_axis_tready;
    assign idx_lo          = r_idx[SLOT_IW-1:0];
    assign scan_issue      = (r_idx < IDX_END);
    assign scan_done       = !r_chk_vld && !scan_issue;

    // A slot expires when it is valid and its deadline is at or before now.
    assign hit        = r_chk_vld && r_valid[r_chk_idx] && (r_now >= r_rd_data);
    // A second expired slot must push the held one out; without room, hold.
    assign tick_stall = hit && r_pend_vld && !out_free;
    assign scan_adv   = (r_state == S_TICK) ? !tick_stall : 1'b1;
    assign mem_re     = ((r_state == S_TICK) || (r_state == S_NEXT)) && scan_adv && scan_issue;

    assign add_dl = r_now + NOW_W'(r_prod);
    assign del_ok = ({1'b0, r_slot} < SLOT_LIM) && r_valid[r_slot[SLOT_IW-1:0]];

    always_comb begin
        emit     = 1'b0;
        add_take = 1'b0;
        e_status = ST_OK;
        e_slot   = '0;
        e_value  = '0;
        e_last   = 1'b1;
        unique case (r_state)
            S_ADD: begin
                priority if (r_idx == IDX_END) begin
                    emit     = out_free;
                    e_status = ST_FULL;
                end else if (!r_valid[idx_lo] && out_free) begin
                    emit     = 1'b1;
                    add_take = 1'b1;
                    e_slot   = SLOT_W'(idx_lo);
                    e_value  = add_dl;
                end else begin
                    // Slot taken or result register busy: keep scanning or wait.
                    emit = 1'b0;
                end
            end
            S_DEL: begin
                emit     = out_free;
                e_status = del_ok ? ST_OK : ST_NOTVALID;
                e_slot   = r_slot;
            end
            S_TICK: begin
                priority if (hit && r_pend_vld && out_free) begin
                    emit    = 1'b1;
                    e_slot  = SLOT_W'(r_pend_slot);
                    e_value = r_pend_dl;
                    e_last  = 1'b0;
                end else if (scan_done && out_free) begin
                    emit = 1'b1;
                    if (r_pend_vld) begin
                        e_slot  = SLOT_W'(r_pend_slot);
                        e_value = r_pend_dl;
                    end else begin
                        e_status = ST_NONE;
                    end
                end else begin
                    // Scan still running with nothing to push out, or the output register busy.
                    emit = 1'b0;
                end
            end
            S_NEXT: begin
                emit    = scan_done && out_free;
                e_value = r_best;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Deadline memory port: the add writes, the scans read.
    always_ff @(posedge i_clk) begin
        if (add_take) begin
            mem_dl[idx_lo] <= add_dl;
        end
        if (mem_re) begin
            r_rd_data <= mem_dl[idx_lo];
        end
    end

    // State, scan control, valid bits, configuration and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_idx      <= '0;
            r_chk_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_tpu      <= TPU_RST;
            r_slice    <= SLICE_RST;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TPU:   r_tpu   <= i_cfg_wdata[TPU_W-1:0];
                    CFG_SLICE: r_slice <= i_cfg_wdata[SLICE_W-1:0];
                    default:   r_tpu   <= r_tpu;
                endcase
            end

            if (emit) begin
                r_out_vld    <= 1'b1;
                r_out_status <= e_status;
                r_out_slot   <= e_slot;
                r_out_value  <= e_value;
                r_out_last   <= e_last;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_now     <= in_now;
                        r_prod    <= PROD_W'(in_delay) * PROD_W'(r_tpu);
                        r_slot    <= in_slot;
                        r_best    <= in_now + NOW_W'(r_slice);
                        r_idx     <= '0;
                        r_chk_vld <= 1'b0;
                        unique case (i_s_axis_tuser)
                            OP_ADD:  r_state <= S_ADD;
                            OP_DEL:  r_state <= S_DEL;
                            OP_TICK: r_state <= S_TICK;
                            OP_NEXT: r_state <= S_NEXT;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_ADD: begin
                    if (add_take) begin
                        r_valid[idx_lo] <= 1'b1;
                    end
                    if (emit) begin
                        r_state <= S_IDLE;
                    end else if ((r_idx != IDX_END) && r_valid[idx_lo]) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DEL: begin
                    if (emit) begin
                        if (del_ok) begin
                            r_valid[r_slot[SLOT_IW-1:0]] <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_TICK, S_NEXT: begin
                    if (scan_adv) begin
                        r_chk_vld <= scan_issue;
                        r_chk_idx <= idx_lo;
                        if (scan_issue) begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                    // Hold the latest expired slot until we know whether it is the last.
                    if ((r_state == S_TICK) && hit && !tick_stall) begin
                        r_pend_vld  <= 1'b1;
                        r_pend_slot <= r_chk_idx;
                        r_pend_dl   <= r_rd_data;
                    end
                    if ((r_state == S_NEXT) && r_chk_vld && r_valid[r_chk_idx] &&
                        (r_rd_data < r_best)) begin
                        r_best <= r_rd_data;
                    end
                    if (scan_done && emit) begin
                        r_pend_vld <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {(M_DATA_W - SLOT_W - NOW_W)'(0), r_out_value, r_out_slot};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // No scan or held expiry may survive into the idle state.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_pend_vld && !r_chk_vld))
        else $error("scan state left over in idle");

    // A held expired slot only exists during a tick scan.
    a_pend_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> (r_state == S_TICK))
        else $error("held expiry outside tick scan");

    // Pool full is reported only when every slot is taken.
    a_full_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (e_status == ST_FULL)) |-> (&r_valid))
        else $error("pool full reported with a free slot");

    // A slot handed out by add is marked valid in the next cycle.
    a_add_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        add_take |=> r_valid[$past(idx_lo)])
        else $error("added slot not marked valid");

    // A none-expired result always closes its item.
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_status == ST_NONE)) |-> r_out_last)
        else $error("none result without last");

endmodule
